// File: design/image_resize_nearest_bilinear_defines.svh
// Assertion macros for the image scaler.
`ifndef IMAGE_RESIZE_NEAREST_BILINEAR_DEFINES_SVH
`define IMAGE_RESIZE_NEAREST_BILINEAR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge outside reset
`define IRS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("irs assertion failed");
// Checked on every edge, reset included
`define IRS_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("irs assertion failed during reset");
`else
`define IRS_ASSERT(lbl, prop)
`define IRS_ASSERT_NR(lbl, prop)
`endif

`endif

// File: design/irs_pkg.sv
// Shared constants, codes and types of the image scaler.
package irs_pkg;

    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_MAX_CHANNELS   = 4;

    localparam int COORD_W     = 10;
    localparam int CHAN_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int RATIO_W     = 25;
    localparam int POS_W       = 27;
    localparam int PROD_W      = 35;
    localparam int SRC_DIM_W   = 9;
    localparam int DST_DIM_W   = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 16;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 25'd65536;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 25'h1FF_FFFF;
    localparam logic [POS_W-1:0]   POS_MAX   = 27'd67108863;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_DST_WIDTH   = 3'd2,
        CFG_DST_HEIGHT  = 3'd3,
        CFG_INTERP_MODE = 3'd4
    } cfg_index_t;

    typedef enum logic {
        MODE_WRITE   = 1'b0,
        MODE_REQUEST = 1'b1
    } mode_t;

    typedef enum logic {
        INTERP_NEAREST  = 1'b0,
        INTERP_BILINEAR = 1'b1
    } interp_t;

    typedef struct packed {
        mode_t                 mode;
        logic [COORD_W-1:0]    column;
        logic [COORD_W-1:0]    row;
        logic [CHAN_W-1:0]     channel;
        logic [SAMPLE_W-1:0]   sample;
    } item_t;

    // Stage enables of the coordinate mapper
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } map_en_t;

    // Stage enables of the blend unit
    typedef struct packed {
        logic s6;
        logic s7;
        logic s8;
    } blend_en_t;

    // Bank selection and weights that follow the store read
    typedef struct packed {
        logic              xpar;
        logic              ypar;
        logic              xsame;
        logic              ysame;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic              zero;
    } blend_sel_t;

endpackage

// File: design/image_resize_nearest_bilinear.sv
// Top level of the nearest / bilinear image scaler.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: column,row,channel,sample_in
//                                                    tuser: mode
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: sample_out
//  cfg       in         cfg_we                       cfg_index, cfg_data
//
// Eight register stages: input, multiply, offset, clamp, store read, row blend,
// column blend, round. One item per cycle while the output takes results and no
// divide runs. The source store is four banks split by pixel parity, so all four
// neighbours come out of one read.
// A size register write reruns the two bit-serial ratio dividers; s_axis_tready
// stays low until both have finished.
// Each stage moves when the next one is empty or moving, so bubbles close up
// under an output stall. Reset clears valid bits and loads register defaults.
`include "image_resize_nearest_bilinear_defines.svh"

module image_resize_nearest_bilinear #(
    parameter int MAX_SRC_WIDTH  = irs_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = irs_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_CHANNELS   = irs_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [9:0] column, [19:10] row, [21:20] channel, [37:22] sample_in, [39:38] unused
    input  logic [irs_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] sample_out
    output logic [irs_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [irs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import irs_pkg::*;

    localparam int XW      = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int YW      = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int XHW     = (XW > 1) ? XW - 1 : 1;
    localparam int YHW     = (YW > 1) ? YW - 1 : 1;
    localparam int CW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BAW     = YHW + XHW + CW;
    localparam int BDEPTH  = 1 << BAW;
    localparam int SWX     = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SWY     = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int NUMX_W  = SWX + FRAC_W;
    localparam int NUMY_W  = SWY + FRAC_W;
    localparam int NS      = 8;
    localparam int ST_RAM  = 5;

    // Configuration registers
    logic [SRC_DIM_W-1:0] src_width_reg, src_height_reg;
    logic [DST_DIM_W-1:0] dst_width_reg, dst_height_reg;
    interp_t              interp_mode_reg;
    logic                 div_start_reg;
    logic                 size_wr;

    always_comb
    begin
        size_wr = cfg_we && (cfg_index == CFG_SRC_WIDTH || cfg_index == CFG_SRC_HEIGHT
                  || cfg_index == CFG_DST_WIDTH || cfg_index == CFG_DST_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= 9'd256;
            src_height_reg  <= 9'd256;
            dst_width_reg   <= 11'd256;
            dst_height_reg  <= 11'd256;
            interp_mode_reg <= INTERP_BILINEAR;
            div_start_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= size_wr;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SRC_WIDTH:   src_width_reg   <= SRC_DIM_W'(cfg_data);
                    CFG_SRC_HEIGHT:  src_height_reg  <= SRC_DIM_W'(cfg_data);
                    CFG_DST_WIDTH:   dst_width_reg   <= cfg_data;
                    CFG_DST_HEIGHT:  dst_height_reg  <= cfg_data;
                    CFG_INTERP_MODE: interp_mode_reg <= interp_t'(cfg_data[0]);
                    default:         ;
                endcase
            end
        end
    end

    // Effective sizes: zero reads as one, source capped at the store size
    logic [SWX-1:0]       eff_w;
    logic [SWY-1:0]       eff_h;
    logic [DST_DIM_W-1:0] den_w, den_h;
    logic [XW-1:0]        wmax;
    logic [YW-1:0]        hmax;

    always_comb
    begin
        if (src_width_reg == '0)
        begin
            eff_w = SWX'(1);
        end
        else if (32'(src_width_reg) > MAX_SRC_WIDTH)
        begin
            eff_w = SWX'(MAX_SRC_WIDTH);
        end
        else
        begin
            eff_w = SWX'(src_width_reg);
        end
        if (src_height_reg == '0)
        begin
            eff_h = SWY'(1);
        end
        else if (32'(src_height_reg) > MAX_SRC_HEIGHT)
        begin
            eff_h = SWY'(MAX_SRC_HEIGHT);
        end
        else
        begin
            eff_h = SWY'(src_height_reg);
        end
        den_w = (dst_width_reg == '0) ? DST_DIM_W'(1) : dst_width_reg;
        den_h = (dst_height_reg == '0) ? DST_DIM_W'(1) : dst_height_reg;
        wmax  = XW'(eff_w - SWX'(1));
        hmax  = YW'(eff_h - SWY'(1));
    end

    // Ratio dividers
    logic               busy_x, busy_y, busy;
    logic [RATIO_W-1:0] x_ratio, y_ratio;

    irs_div #(.NUM_W(NUMX_W)) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   ({eff_w, FRAC_W'(0)}),
        .den   (den_w),
        .busy  (busy_x),
        .quot  (x_ratio)
    );

    irs_div #(.NUM_W(NUMY_W)) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   ({eff_h, FRAC_W'(0)}),
        .den   (den_h),
        .busy  (busy_y),
        .quot  (y_ratio)
    );

    assign busy = div_start_reg || busy_x || busy_y;

    // Stage valid bits and per-stage load enables
    logic [NS:1]   v_reg, v_next;
    logic [NS+1:1] go;
    item_t         item_reg [1:4];
    item_t         item_in;

    always_comb
    begin
        go[NS+1] = m_axis_tready;
        for (int i = NS; i >= 1; i--)
        begin
            go[i] = !v_reg[i] || go[i+1];
        end
    end

    assign s_axis_tready = go[1] && !busy;

    always_comb
    begin
        v_next = v_reg;
        if (go[1])
        begin
            v_next[1] = s_axis_tvalid && !busy;
        end
        for (int i = 2; i <= NS; i++)
        begin
            if (go[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
        // Writes end at the store
        if (go[ST_RAM])
        begin
            v_next[ST_RAM] = v_reg[ST_RAM-1] && (item_reg[4].mode == MODE_REQUEST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Item fields ride along to the store stage
    always_comb
    begin
        item_in.mode    = mode_t'(s_axis_tuser);
        item_in.column  = s_axis_tdata[9:0];
        item_in.row     = s_axis_tdata[19:10];
        item_in.channel = s_axis_tdata[21:20];
        item_in.sample  = s_axis_tdata[37:22];
    end

    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            item_reg[1] <= item_in;
        end
        for (int i = 2; i <= 4; i++)
        begin
            if (go[i])
            begin
                item_reg[i] <= item_reg[i-1];
            end
        end
    end

    // Coordinate mapping, stages 2 to 4
    map_en_t           map_en;
    logic              nearest;
    logic [XW-1:0]     xlo;
    logic [YW-1:0]     ylo;
    logic              xsame, ysame;
    logic [FRAC_W-1:0] fx, fy;

    assign map_en  = '{s2: go[2], s3: go[3], s4: go[4]};
    assign nearest = (interp_mode_reg == INTERP_NEAREST);

    irs_axis #(.IDX_W(XW)) u_axis_x (
        .clk     (clk),
        .en      (map_en),
        .coord   (item_reg[1].column),
        .ratio   (x_ratio),
        .max_idx (wmax),
        .nearest (nearest),
        .lo      (xlo),
        .same    (xsame),
        .frac    (fx)
    );

    irs_axis #(.IDX_W(YW)) u_axis_y (
        .clk     (clk),
        .en      (map_en),
        .coord   (item_reg[1].row),
        .ratio   (y_ratio),
        .max_idx (hmax),
        .nearest (nearest),
        .lo      (ylo),
        .same    (ysame),
        .frac    (fy)
    );

    // Store banks by pixel parity; the even bank of a pair sits at (lo+1)/2
    logic [XHW-1:0]      x_even_h, x_odd_h, wx_h;
    logic [YHW-1:0]      y_even_h, y_odd_h, wy_h;
    logic [CW-1:0]       ch_idx;
    logic                wr_ok;
    logic [1:0]          wr_bank;
    logic [BAW-1:0]      waddr;
    logic [SAMPLE_W-1:0] bank_data [4];
    blend_sel_t          sel_reg, sel_next;

    always_comb
    begin
        x_even_h = XHW'(({1'b0, xlo} + (XW + 1)'(1)) >> 1);
        x_odd_h  = XHW'(xlo >> 1);
        y_even_h = YHW'(({1'b0, ylo} + (YW + 1)'(1)) >> 1);
        y_odd_h  = YHW'(ylo >> 1);
        ch_idx   = CW'(item_reg[4].channel);
        wr_ok    = go[ST_RAM] && v_reg[ST_RAM-1] && (item_reg[4].mode == MODE_WRITE)
                   && (32'(item_reg[4].column) < MAX_SRC_WIDTH)
                   && (32'(item_reg[4].row) < MAX_SRC_HEIGHT)
                   && (32'(item_reg[4].channel) < MAX_CHANNELS);
        wr_bank  = {item_reg[4].row[0], item_reg[4].column[0]};
        wx_h     = XHW'(item_reg[4].column >> 1);
        wy_h     = YHW'(item_reg[4].row >> 1);
        waddr    = {wy_h, wx_h, ch_idx};
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [BAW-1:0] raddr;
        assign raddr = {(b / 2 == 1) ? y_odd_h : y_even_h,
                        (b % 2 == 1) ? x_odd_h : x_even_h, ch_idx};
        irs_ram #(.WIDTH(SAMPLE_W), .DEPTH(BDEPTH)) u_bank (
            .clk   (clk),
            .we    (wr_ok && (wr_bank == 2'(b))),
            .waddr (waddr),
            .wdata (item_reg[4].sample),
            .re    (go[ST_RAM]),
            .raddr (raddr),
            .rdata (bank_data[b])
        );
    end

    // Selection data in step with the store read
    always_comb
    begin
        sel_next.xpar  = xlo[0];
        sel_next.ypar  = ylo[0];
        sel_next.xsame = xsame;
        sel_next.ysame = ysame;
        sel_next.fx    = fx;
        sel_next.fy    = fy;
        sel_next.zero  = (32'(item_reg[4].channel) >= MAX_CHANNELS);
    end

    always_ff @(posedge clk)
    begin
        if (go[ST_RAM])
        begin
            sel_reg <= sel_next;
        end
    end

    // Blend, stages 6 to 8
    blend_en_t blend_en;

    assign blend_en = '{s6: go[6], s7: go[7], s8: go[8]};

    irs_blend u_blend (
        .clk        (clk),
        .en         (blend_en),
        .sel        (sel_reg),
        .bank_data  (bank_data),
        .sample_out (m_axis_tdata)
    );

    assign m_axis_tvalid = v_reg[NS];

    `IRS_ASSERT(a_no_transfer_while_dividing, s_axis_tready |-> !busy)
    `IRS_ASSERT(a_write_leaves_at_store, (v_reg[4] && item_reg[4].mode == MODE_WRITE && go[5]) |=> !v_reg[5])
    `IRS_ASSERT(a_size_write_starts_divide, size_wr |=> busy)
    `IRS_ASSERT_NR(a_no_result_in_reset, !rst_n |-> !m_axis_tvalid)

endmodule

// File: design/irs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module irs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/irs_div.sv
// Bit-serial ratio divider: (numerator) / den, saturated to the ratio width.
module irs_div #(
    parameter int NUM_W = 25
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_W-1:0]                num,
    input  logic [irs_pkg::DST_DIM_W-1:0]   den,
    output logic                            busy,
    output logic [irs_pkg::RATIO_W-1:0]     quot
);
    import irs_pkg::*;

    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int WIDE_W = (NUM_W > RATIO_W) ? NUM_W : RATIO_W;

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RATIO_W-1:0]   quot_reg, quot_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [DST_DIM_W-1:0] rem_reg, rem_next;
    logic [DST_DIM_W-1:0] den_reg, den_next;
    logic [DST_DIM_W:0]   trial;
    logic                 qbit;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DST_DIM_W'(trial - {1'b0, den_reg}) : DST_DIM_W'(trial);
            q_next   = {q_reg[NUM_W-2:0], qbit};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                if (WIDE_W'(q_next) > WIDE_W'(RATIO_MAX))
                begin
                    quot_next = RATIO_MAX;
                end
                else
                begin
                    quot_next = RATIO_W'(q_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= RATIO_ONE;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// File: design/irs_axis.sv
// One axis of the coordinate mapper: scale, offset and clamp, three stages.
module irs_axis #(
    parameter int IDX_W = 8
) (
    input  logic                          clk,
    input  irs_pkg::map_en_t              en,
    input  logic [irs_pkg::COORD_W-1:0]   coord,
    input  logic [irs_pkg::RATIO_W-1:0]   ratio,
    input  logic [IDX_W-1:0]              max_idx,
    input  logic                          nearest,
    output logic [IDX_W-1:0]              lo,
    output logic                          same,
    output logic [irs_pkg::FRAC_W-1:0]    frac
);
    import irs_pkg::*;

    localparam int WIDE_W = PROD_W + 2;
    localparam int CMP_W  = 12;

    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic signed [WIDE_W-1:0] wide;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic                     same_reg, same_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic                     neg;
    logic [CMP_W-1:0]         fl_u, max_u, near_raw, near_c, lo_b, hi_raw, hi_b;

    // Stage 2: coordinate times ratio
    assign prod_next = PROD_W'(coord) * PROD_W'(ratio);

    // Stage 3: add half ratio, subtract one half, saturate on top
    always_comb
    begin
        wide = $signed({2'b00, prod_reg}) + $signed(WIDE_W'(ratio >> 1))
             - $signed(WIDE_W'(32768));
        if (wide > $signed(WIDE_W'(POS_MAX)))
        begin
            pos_next = $signed(POS_MAX);
        end
        else
        begin
            pos_next = POS_W'(wide);
        end
    end

    // Stage 4: neighbour indices and fraction, clamped to the image
    always_comb
    begin
        neg      = pos_reg[POS_W-1];
        fl_u     = CMP_W'(pos_reg[POS_W-2:FRAC_W]);
        max_u    = CMP_W'(max_idx);
        near_raw = neg ? '0 : fl_u + CMP_W'(pos_reg[FRAC_W-1]);
        near_c   = (near_raw > max_u) ? max_u : near_raw;
        lo_b     = neg ? '0 : ((fl_u > max_u) ? max_u : fl_u);
        hi_raw   = neg ? '0 : fl_u + CMP_W'(1);
        hi_b     = (hi_raw > max_u) ? max_u : hi_raw;
        if (nearest)
        begin
            lo_next   = IDX_W'(near_c);
            same_next = 1'b1;
            frac_next = '0;
        end
        else
        begin
            lo_next   = IDX_W'(lo_b);
            same_next = (hi_b == lo_b);
            frac_next = pos_reg[FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_reg <= prod_next;
        end
        if (en.s3)
        begin
            pos_reg <= pos_next;
        end
        if (en.s4)
        begin
            lo_reg   <= lo_next;
            same_reg <= same_next;
            frac_reg <= frac_next;
        end
    end

    assign lo   = lo_reg;
    assign same = same_reg;
    assign frac = frac_reg;

endmodule

// File: design/irs_blend.sv
// Bilinear blend of four store samples, rounding and output register.
module irs_blend (
    input  logic                           clk,
    input  irs_pkg::blend_en_t             en,
    input  irs_pkg::blend_sel_t            sel,
    input  logic [irs_pkg::SAMPLE_W-1:0]   bank_data [4],
    output logic [irs_pkg::SAMPLE_W-1:0]   sample_out
);
    import irs_pkg::*;

    logic              ax, bx, ay, by;
    logic [SAMPLE_W-1:0] pa, pb, pc, pd;
    logic [FRAC_W:0]   wx, wy;
    logic [31:0]       r1_reg, r1_next, r2_reg, r2_next;
    logic [FRAC_W-1:0] fy_reg;
    logic              zero6_reg, zero7_reg, zero8;
    logic [47:0]       sum_reg, sum_next;
    logic [48:0]       rnd;
    logic [16:0]       q;
    logic [SAMPLE_W-1:0] out_reg, out_next;

    // Stage 6: pick banks and blend along the row
    always_comb
    begin
        ax = sel.xpar;
        bx = sel.xsame ? sel.xpar : ~sel.xpar;
        ay = sel.ypar;
        by = sel.ysame ? sel.ypar : ~sel.ypar;
        pa = bank_data[{ay, ax}];
        pb = bank_data[{ay, bx}];
        pc = bank_data[{by, ax}];
        pd = bank_data[{by, bx}];
        wx = 17'd65536 - 17'(sel.fx);
        r1_next = 32'(33'(pa) * 33'(wx) + 33'(pb) * 33'(sel.fx));
        r2_next = 32'(33'(pc) * 33'(wx) + 33'(pd) * 33'(sel.fx));
    end

    // Stage 7: blend the two rows
    always_comb
    begin
        wy       = 17'd65536 - 17'(fy_reg);
        sum_next = 48'(49'(r1_reg) * 49'(wy) + 49'(r2_reg) * 49'(fy_reg));
    end

    // Stage 8: round half up, saturate
    always_comb
    begin
        rnd   = 49'(sum_reg) + 49'h0_0000_8000_0000;
        q     = rnd[48:32];
        zero8 = zero7_reg;
        if (zero8)
        begin
            out_next = '0;
        end
        else if (q > 17'd65535)
        begin
            out_next = '1;
        end
        else
        begin
            out_next = q[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            fy_reg    <= sel.fy;
            zero6_reg <= sel.zero;
        end
        if (en.s7)
        begin
            sum_reg   <= sum_next;
            zero7_reg <= zero6_reg;
        end
        if (en.s8)
        begin
            out_reg <= out_next;
        end
    end

    assign sample_out = out_reg;

endmodule
